### hw/rtl/skrt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_pkg
// Shared sizes, codes and helpers of the sorted key record table.
// ----------------------------------------------------------------------------
package skrt_pkg;

  localparam int DEPTH         = 32;
  localparam int PAYLOAD_WIDTH = 64;

  localparam int KEY_W      = 32;
  localparam int PAY_PORT_W = 64;
  localparam int INDEX_W    = 5;
  localparam int COUNT_W    = 6;
  localparam int STATUS_W   = 3;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int ENTRY_W    = KEY_W + PAYLOAD_WIDTH;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUP       = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_DN,
    S_SHIFT_UP
  } state_t;

  // low bits of a position, zero extended where the position is narrower
  function automatic logic [INDEX_W-1:0] to_index(input logic [CNT_W-1:0] p);
    logic [INDEX_W-1:0] r;
    r = '0;
    for (int b = 0; b < INDEX_W; b++) begin
      if (b < CNT_W) r[b] = p[b];
    end
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = '0;
    for (int b = 0; b < COUNT_W; b++) begin
      if (b < CNT_W) r[b] = c[b];
    end
    return r;
  endfunction

  function automatic logic [PAY_PORT_W-1:0] ext_payload(
    input logic [PAYLOAD_WIDTH-1:0] p
  );
    logic [PAY_PORT_W-1:0] r;
    r = '0;
    for (int b = 0; b < PAYLOAD_WIDTH; b++) begin
      r[b] = p[b];
    end
    return r;
  endfunction

  function automatic logic [PAYLOAD_WIDTH-1:0] cut_payload(
    input logic [PAY_PORT_W-1:0] p
  );
    logic [PAYLOAD_WIDTH-1:0] r;
    for (int b = 0; b < PAYLOAD_WIDTH; b++) begin
      r[b] = p[b];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/skrt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module skrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_key_record_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_record_table_top
// Table of key/payload records kept in ascending key order in one RAM.
// Insert, delete, find and list commands, one command at a time.
// Find, delete and insert use a linear scan; delete and insert may then do a
//   one-entry-per-cycle shift through the single read and single write port
//   of the RAM. List gives one word per cycle once its first word is out;
//   busy is high while a command runs.
// Reset clears the entry count and control; the RAM holds no reset value.
// ----------------------------------------------------------------------------
module sorted_key_record_table_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        cmd,
  input  wire logic [skrt_pkg::KEY_W-1:0]        key,
  input  wire logic [skrt_pkg::PAY_PORT_W-1:0]   payload,
  output logic                                   strobe,
  output logic [skrt_pkg::STATUS_W-1:0]          status,
  output logic [skrt_pkg::INDEX_W-1:0]           index,
  output logic [skrt_pkg::KEY_W-1:0]             key_out,
  output logic [skrt_pkg::PAY_PORT_W-1:0]        payload_out,
  output logic [skrt_pkg::COUNT_W-1:0]           count,
  output logic                                   last
);

  localparam int AW = skrt_pkg::ADDR_W;
  localparam int CW = skrt_pkg::CNT_W;
  localparam int PW = skrt_pkg::PAYLOAD_WIDTH;
  localparam int KW = skrt_pkg::KEY_W;
  localparam int EW = skrt_pkg::ENTRY_W;

  skrt_pkg::state_t state, state_next;

  skrt_pkg::cmd_t  cmd_r, cmd_r_next;
  logic [KW-1:0]   key_r, key_r_next;
  logic [PW-1:0]   pay_r, pay_r_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic [CW-1:0]   ptr, ptr_next;
  logic            pend_vld, pend_vld_next;
  logic [AW-1:0]   pend_idx, pend_idx_next;
  logic            walk, walk_next;
  logic [AW-1:0]   pos, pos_next;
  logic [KW-1:0]   hold_key, hold_key_next;
  logic [PW-1:0]   hold_pay, hold_pay_next;

  logic            rd_en, wr_en;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [EW-1:0]   rd_data, wr_data;

  logic                res_vld, res_last;
  skrt_pkg::status_t   res_status;
  logic [CW-1:0]       res_pos;
  logic [KW-1:0]       res_key;
  logic [PW-1:0]       res_pay;

  logic [KW-1:0]   cur_key;
  logic [PW-1:0]   cur_pay;
  logic            hit_eq, hit_gt, scan_end, decide, list_last, is_full, go_up, go_dn;
  logic [CW-1:0]   pend_pos;

  skrt_ram #(
    .WIDTH (EW),
    .DEPTH (skrt_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy      = (state != skrt_pkg::S_IDLE);
  assign cur_key   = rd_data[EW-1:PW];
  assign cur_pay   = rd_data[PW-1:0];
  assign pend_pos  = CW'(pend_idx);
  assign hit_eq    = pend_vld && (cur_key == key_r);
  assign hit_gt    = pend_vld && (cur_key > key_r);
  assign scan_end  = !pend_vld && (ptr == cnt);
  assign decide    = hit_eq || hit_gt || scan_end;
  assign list_last = pend_vld && ((pend_pos + CW'(1)) == cnt);
  assign is_full   = (cnt == CW'(skrt_pkg::DEPTH));
  assign go_up     = (cmd_r == skrt_pkg::CMD_INSERT) && !hit_eq && !is_full && hit_gt;
  assign go_dn     = (cmd_r == skrt_pkg::CMD_DELETE) && hit_eq &&
                     ((pend_pos + CW'(1)) < cnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      skrt_pkg::S_IDLE: begin
        if (start && !(skrt_pkg::cmd_t'(cmd) == skrt_pkg::CMD_LIST && cnt == '0))
          state_next = skrt_pkg::S_SCAN;
      end
      skrt_pkg::S_SCAN: begin
        if (cmd_r == skrt_pkg::CMD_LIST) begin
          if (list_last) state_next = skrt_pkg::S_IDLE;
        end else if (decide) begin
          priority if (go_up) state_next = skrt_pkg::S_SHIFT_UP;
          else if (go_dn)     state_next = skrt_pkg::S_SHIFT_DN;
          else                state_next = skrt_pkg::S_IDLE;
        end
      end
      skrt_pkg::S_SHIFT_DN,
      skrt_pkg::S_SHIFT_UP: begin
        if (!walk && !pend_vld) state_next = skrt_pkg::S_IDLE;
      end
      default: state_next = skrt_pkg::S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    rd_en         = 1'b0;
    rd_addr       = ptr[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = pend_idx;
    wr_data       = rd_data;
    cmd_r_next    = cmd_r;
    key_r_next    = key_r;
    pay_r_next    = pay_r;
    cnt_next      = cnt;
    ptr_next      = ptr;
    pend_vld_next = 1'b0;
    pend_idx_next = pend_idx;
    walk_next     = walk;
    pos_next      = pos;
    hold_key_next = hold_key;
    hold_pay_next = hold_pay;
    res_vld       = 1'b0;
    res_last      = 1'b1;
    res_status    = skrt_pkg::ST_OK;
    res_pos       = '0;
    res_key       = '0;
    res_pay       = '0;

    unique case (state)
      skrt_pkg::S_IDLE: begin
        if (start) begin
          cmd_r_next = skrt_pkg::cmd_t'(cmd);
          key_r_next = key;
          pay_r_next = skrt_pkg::cut_payload(payload);
          ptr_next   = '0;
          if (skrt_pkg::cmd_t'(cmd) == skrt_pkg::CMD_LIST && cnt == '0) begin
            res_vld    = 1'b1;
            res_status = skrt_pkg::ST_EMPTY;
          end
        end
      end

      skrt_pkg::S_SCAN: begin
        if (cmd_r == skrt_pkg::CMD_LIST) begin
          if (ptr < cnt) begin
            rd_en         = 1'b1;
            ptr_next      = ptr + CW'(1);
            pend_vld_next = 1'b1;
            pend_idx_next = ptr[AW-1:0];
          end
          if (pend_vld) begin
            res_vld  = 1'b1;
            res_pos  = pend_pos;
            res_key  = cur_key;
            res_pay  = cur_pay;
            res_last = list_last;
          end
        end else if (!decide) begin
          if (ptr < cnt) begin
            rd_en         = 1'b1;
            ptr_next      = ptr + CW'(1);
            pend_vld_next = 1'b1;
            pend_idx_next = ptr[AW-1:0];
          end
        end else begin
          res_vld = !(go_up || go_dn);
          unique case (cmd_r)
            skrt_pkg::CMD_INSERT: begin
              priority if (hit_eq) begin
                res_status = skrt_pkg::ST_DUP;
                res_pos    = pend_pos;
                res_key    = cur_key;
                res_pay    = cur_pay;
              end else if (is_full) begin
                res_status = skrt_pkg::ST_FULL;
              end else if (hit_gt) begin
                pos_next  = pend_idx;
                ptr_next  = cnt - CW'(1);
                walk_next = 1'b1;
              end else begin
                wr_en    = 1'b1;
                wr_addr  = cnt[AW-1:0];
                wr_data  = {key_r, pay_r};
                cnt_next = cnt + CW'(1);
                res_pos  = cnt;
                res_key  = key_r;
                res_pay  = pay_r;
              end
            end
            skrt_pkg::CMD_DELETE: begin
              if (hit_eq) begin
                hold_key_next = cur_key;
                hold_pay_next = cur_pay;
                pos_next      = pend_idx;
                if (go_dn) begin
                  ptr_next  = pend_pos + CW'(1);
                  walk_next = 1'b1;
                end else begin
                  cnt_next = cnt - CW'(1);
                  res_pos  = pend_pos;
                  res_key  = cur_key;
                  res_pay  = cur_pay;
                end
              end else begin
                res_status = skrt_pkg::ST_NOT_FOUND;
              end
            end
            skrt_pkg::CMD_FIND: begin
              if (hit_eq) begin
                res_pos = pend_pos;
                res_key = cur_key;
                res_pay = cur_pay;
              end else begin
                res_status = skrt_pkg::ST_NOT_FOUND;
              end
            end
            skrt_pkg::CMD_LIST: begin
              res_vld = 1'b0;
            end
            default: res_vld = 1'b0;
          endcase
        end
      end

      skrt_pkg::S_SHIFT_DN: begin
        if (pend_vld) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx - AW'(1);
        end
        if (walk) begin
          rd_en         = 1'b1;
          pend_vld_next = 1'b1;
          pend_idx_next = ptr[AW-1:0];
          if ((ptr + CW'(1)) == cnt) walk_next = 1'b0;
          else                       ptr_next  = ptr + CW'(1);
        end
        if (!walk && !pend_vld) begin
          cnt_next = cnt - CW'(1);
          res_vld  = 1'b1;
          res_pos  = CW'(pos);
          res_key  = hold_key;
          res_pay  = hold_pay;
        end
      end

      skrt_pkg::S_SHIFT_UP: begin
        if (pend_vld) begin
          wr_en   = 1'b1;
          wr_addr = pend_idx + AW'(1);
        end
        if (walk) begin
          rd_en         = 1'b1;
          pend_vld_next = 1'b1;
          pend_idx_next = ptr[AW-1:0];
          if (ptr[AW-1:0] == pos) walk_next = 1'b0;
          else                    ptr_next  = ptr - CW'(1);
        end
        if (!walk && !pend_vld) begin
          wr_en    = 1'b1;
          wr_addr  = pos;
          wr_data  = {key_r, pay_r};
          cnt_next = cnt + CW'(1);
          res_vld  = 1'b1;
          res_pos  = CW'(pos);
          res_key  = key_r;
          res_pay  = pay_r;
        end
      end

      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= skrt_pkg::S_IDLE;
      cnt      <= '0;
      pend_vld <= 1'b0;
      walk     <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      pend_vld <= pend_vld_next;
      walk     <= walk_next;
      strobe   <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_r_next;
    key_r    <= key_r_next;
    pay_r    <= pay_r_next;
    ptr      <= ptr_next;
    pend_idx <= pend_idx_next;
    pos      <= pos_next;
    hold_key <= hold_key_next;
    hold_pay <= hold_pay_next;
    if (res_vld) begin
      status      <= res_status;
      index       <= skrt_pkg::to_index(res_pos);
      key_out     <= res_key;
      payload_out <= skrt_pkg::ext_payload(res_pay);
      count       <= skrt_pkg::to_count(cnt_next);
      last        <= res_last;
    end
  end

endmodule
`default_nettype wire
